/* hdl/sha1_message_digest_assert.svh */
// Assertion macros shared by the SHA-1 digest checker.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Checked at every clock edge outside reset.
`define SHA1MD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SHA1MD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/sha1md_pkg.sv */
// Types, constants and round functions of the SHA-1 digest block.
package sha1md_pkg;

  typedef enum logic [0:0] {
    CMD_DATA,
    CMD_TAIL
  } cmd_kind_e;

  typedef struct packed {
    logic [31:0] word;
    cmd_kind_e   kind;
    logic [5:0]  nbits;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } back_state_e;

  typedef logic [4:0][31:0] digest_t;

  typedef struct packed {
    logic        push;
    logic [31:0] push_word;
    logic        start;
    logic        round_en;
    logic [6:0]  rnd;
    logic        add;
    logic        reinit;
  } core_ctl_t;

  localparam digest_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                            32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] PAD_WORD   = 32'h80000000;
  localparam logic [5:0]  WORD_BITS  = 6'd32;
  localparam logic [6:0]  ROUND_LAST = 7'd79;
  localparam logic [3:0]  POS_LEN_HI = 4'd14;
  localparam logic [3:0]  POS_LAST   = 4'd15;
  localparam logic [2:0]  IDX_LAST   = 3'd4;

  function automatic logic [31:0] sha1md_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    if (r < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      res = b ^ c ^ d;
    end else if (r < 7'd60) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  function automatic logic [31:0] sha1md_k(input logic [6:0] r);
    logic [31:0] res;
    if (r < 7'd20) begin
      res = K0;
    end else if (r < 7'd40) begin
      res = K1;
    end else if (r < 7'd60) begin
      res = K2;
    end else begin
      res = K3;
    end
    return res;
  endfunction

endpackage

/* hdl/sha1md_fifo.sv */
// Small first-in first-out queue between the front and back parts.
module sha1md_fifo #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/sha1md_front.sv */
// Front part: takes input words and turns them into buffer commands.
module sha1md_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,
  input  logic               s_axis_tlast,
  input  logic [2:0]         s_axis_tuser,
  output logic               push_o,
  output sha1md_pkg::cmd_t   push_cmd_o,
  input  logic               full_i
);

  logic pend_q, pend_d;
  logic accept;

  assign s_axis_tready = !full_i && !pend_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pend_d           = pend_q;
    push_o           = 1'b0;
    push_cmd_o.word  = s_axis_tdata;
    push_cmd_o.kind  = sha1md_pkg::CMD_DATA;
    push_cmd_o.nbits = sha1md_pkg::WORD_BITS;
    if (pend_q) begin
      // A full final word still owes the pad byte as a word of its own.
      if (!full_i) begin
        push_o           = 1'b1;
        push_cmd_o.word  = sha1md_pkg::PAD_WORD;
        push_cmd_o.kind  = sha1md_pkg::CMD_TAIL;
        push_cmd_o.nbits = '0;
        pend_d           = 1'b0;
      end
    end else if (accept) begin
      push_o = 1'b1;
      if (s_axis_tlast) begin
        push_cmd_o.kind = sha1md_pkg::CMD_TAIL;
        case (s_axis_tuser)
          3'd0: begin
            push_cmd_o.word  = sha1md_pkg::PAD_WORD;
            push_cmd_o.nbits = 6'd0;
          end
          3'd1: begin
            push_cmd_o.word  = {s_axis_tdata[31:24], 24'h800000};
            push_cmd_o.nbits = 6'd8;
          end
          3'd2: begin
            push_cmd_o.word  = {s_axis_tdata[31:16], 16'h8000};
            push_cmd_o.nbits = 6'd16;
          end
          3'd3: begin
            push_cmd_o.word  = {s_axis_tdata[31:8], 8'h80};
            push_cmd_o.nbits = 6'd24;
          end
          default: begin
            // Four or more valid bytes: the word goes in whole.
            push_cmd_o.kind = sha1md_pkg::CMD_DATA;
            pend_d          = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

endmodule

/* hdl/sha1md_core.sv */
// Compression datapath: message schedule window, working words and chaining words.
module sha1md_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha1md_pkg::core_ctl_t ctl_i,
  output sha1md_pkg::digest_t   hash_o
);

  logic [15:0][31:0]   w_q, w_d;
  logic [4:0][31:0]    st_q, st_d;
  sha1md_pkg::digest_t h_q, h_d;
  logic [31:0]         wx, wnew, tmp;

  assign hash_o = h_q;

  always_comb begin
    wx   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wnew = {wx[30:0], wx[31]};
    tmp  = {st_q[0][26:0], st_q[0][31:27]}
         + sha1md_pkg::sha1md_f(ctl_i.rnd, st_q[1], st_q[2], st_q[3])
         + st_q[4] + w_q[0] + sha1md_pkg::sha1md_k(ctl_i.rnd);

    w_d  = w_q;
    st_d = st_q;
    h_d  = h_q;
    if (ctl_i.push) begin
      w_d = {ctl_i.push_word, w_q[15:1]};
    end else if (ctl_i.round_en) begin
      w_d = {wnew, w_q[15:1]};
    end
    if (ctl_i.start) begin
      st_d = h_q;
    end else if (ctl_i.round_en) begin
      st_d = {st_q[3], st_q[2], {st_q[1][1:0], st_q[1][31:2]}, st_q[0], tmp};
    end
    if (ctl_i.add) begin
      for (int i = 0; i < 5; i++) begin
        h_d[i] = h_q[i] + st_q[i];
      end
    end else if (ctl_i.reinit) begin
      h_d = sha1md_pkg::IV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
      h_q  <= sha1md_pkg::IV;
    end else begin
      st_q <= st_d;
      h_q  <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

endmodule

/* hdl/sha1md_back.sv */
// Back part: block filling, padding, round sequencing and digest output.
module sha1md_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  sha1md_pkg::cmd_t   cmd_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,
  output logic               m_axis_tlast
);

  sha1md_pkg::back_state_e state_q, state_d;
  sha1md_pkg::core_ctl_t   ctl;
  sha1md_pkg::digest_t     hash;

  logic [3:0]  wpos_q, wpos_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        extra_q, extra_d;
  logic        lastblk_q, lastblk_d;
  logic        retpad_q, retpad_d;
  logic        ov_q, ov_d;
  logic [31:0] odata_q, odata_d;
  logic        olast_q, olast_d;
  logic        oload;
  logic [31:0] hsel;

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

  always_comb begin
    case (oidx_q)
      3'd0:    hsel = hash[0];
      3'd1:    hsel = hash[1];
      3'd2:    hsel = hash[2];
      3'd3:    hsel = hash[3];
      default: hsel = hash[4];
    endcase
  end

  always_comb begin
    state_d   = state_q;
    wpos_d    = wpos_q;
    bitlen_d  = bitlen_q;
    rnd_d     = rnd_q;
    oidx_d    = oidx_q;
    extra_d   = extra_q;
    lastblk_d = lastblk_q;
    retpad_d  = retpad_q;
    pop_o     = 1'b0;
    oload     = 1'b0;
    ctl       = '0;
    ctl.rnd   = rnd_q;

    case (state_q)
      sha1md_pkg::ST_LOAD: begin
        if (!empty_i) begin
          pop_o         = 1'b1;
          ctl.push      = 1'b1;
          ctl.push_word = cmd_i.word;
          wpos_d        = wpos_q + 1'b1;
          bitlen_d      = bitlen_q + 64'(cmd_i.nbits);
          retpad_d      = (cmd_i.kind == sha1md_pkg::CMD_TAIL);
          extra_d       = (wpos_q == sha1md_pkg::POS_LEN_HI);
          lastblk_d     = 1'b0;
          if (wpos_q == sha1md_pkg::POS_LAST) begin
            ctl.start = 1'b1;
            state_d   = sha1md_pkg::ST_ROUND;
          end else if (cmd_i.kind == sha1md_pkg::CMD_TAIL) begin
            state_d = sha1md_pkg::ST_PAD;
          end
        end
      end
      sha1md_pkg::ST_PAD: begin
        ctl.push = 1'b1;
        wpos_d   = wpos_q + 1'b1;
        if (!extra_q && wpos_q == sha1md_pkg::POS_LEN_HI) begin
          ctl.push_word = bitlen_q[63:32];
        end else if (!extra_q && wpos_q == sha1md_pkg::POS_LAST) begin
          ctl.push_word = bitlen_q[31:0];
        end
        if (wpos_q == sha1md_pkg::POS_LAST) begin
          ctl.start = 1'b1;
          lastblk_d = !extra_q;
          extra_d   = 1'b0;
          state_d   = sha1md_pkg::ST_ROUND;
        end
      end
      sha1md_pkg::ST_ROUND: begin
        ctl.round_en = 1'b1;
        if (rnd_q == sha1md_pkg::ROUND_LAST) begin
          rnd_d   = '0;
          state_d = sha1md_pkg::ST_ADD;
        end else begin
          rnd_d = rnd_q + 1'b1;
        end
      end
      sha1md_pkg::ST_ADD: begin
        ctl.add = 1'b1;
        oidx_d  = '0;
        if (lastblk_q) begin
          state_d = sha1md_pkg::ST_OUT;
        end else if (retpad_q) begin
          state_d = sha1md_pkg::ST_PAD;
        end else begin
          state_d = sha1md_pkg::ST_LOAD;
        end
      end
      sha1md_pkg::ST_OUT: begin
        if (!ov_q || m_axis_tready) begin
          oload = 1'b1;
          if (oidx_q == sha1md_pkg::IDX_LAST) begin
            // The last chaining word is captured as the state returns to the start values.
            ctl.reinit = 1'b1;
            wpos_d     = '0;
            bitlen_d   = '0;
            lastblk_d  = 1'b0;
            retpad_d   = 1'b0;
            state_d    = sha1md_pkg::ST_LOAD;
          end else begin
            oidx_d = oidx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = sha1md_pkg::ST_LOAD;
      end
    endcase

    odata_d = odata_q;
    olast_d = olast_q;
    ov_d    = ov_q && !m_axis_tready;
    if (oload) begin
      ov_d    = 1'b1;
      odata_d = hsel;
      olast_d = (oidx_q == sha1md_pkg::IDX_LAST);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha1md_pkg::ST_LOAD;
      wpos_q    <= '0;
      bitlen_q  <= '0;
      rnd_q     <= '0;
      oidx_q    <= '0;
      extra_q   <= 1'b0;
      lastblk_q <= 1'b0;
      retpad_q  <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      wpos_q    <= wpos_d;
      bitlen_q  <= bitlen_d;
      rnd_q     <= rnd_d;
      oidx_q    <= oidx_d;
      extra_q   <= extra_d;
      lastblk_q <= lastblk_d;
      retpad_q  <= retpad_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    olast_q <= olast_d;
  end

  sha1md_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .hash_o (hash)
  );

endmodule

/* hdl/sha1_message_digest.sv */
// Top level of the SHA-1 message digest block.
//
//   Channel  Dir  Handshake                    Payload
//   s_axis   in   s_axis_tvalid/s_axis_tready  tdata message word, tlast final, tuser bytes
//   m_axis   out  m_axis_tvalid/m_axis_tready  tdata digest word, tlast marks H4
//
// A request accepted on s_axis is pushed straight into the command queue. The back part moves
// one queued word a cycle into the 16-word schedule window while it loads and the queue is not
// empty; each full block then holds it for 80 rounds of the single round unit plus one chaining
// add. A final word adds padding pushes, one or two compressions and five digest words.
// Reset is asynchronous and active low; there is no clearing pass. A stall on m_axis holds
// the output register; s_axis keeps filling the queue until FIFO_DEPTH commands wait.
module sha1_message_digest #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] message_word
  input  logic        s_axis_tlast,   // final_word
  input  logic [2:0]  s_axis_tuser,   // [2:0] valid_bytes
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic        m_axis_tlast    // digest_last
);

  localparam int CmdW = $bits(sha1md_pkg::cmd_t);

  // The front part splits a full final word into the word itself and a pad-only tail.
  logic             q_push, q_full, q_pop, q_empty;
  sha1md_pkg::cmd_t q_in_cmd, q_out_cmd;
  logic [CmdW-1:0]  q_out_bits;

  assign q_out_cmd = sha1md_pkg::cmd_t'(q_out_bits);

  sha1md_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (q_push),
    .push_cmd_o    (q_in_cmd),
    .full_i        (q_full)
  );

  sha1md_fifo #(
    .WIDTH (CmdW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_out_bits),
    .empty_o     (q_empty)
  );

  // The back part owns the block buffer, the bit count and the round sequencing.
  sha1md_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .cmd_i         (q_out_cmd),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* hdl/sha1md_checker.sv */
// Port-level checker for the SHA-1 digest block and its bind.
`include "sha1_message_digest_assert.svh"

module sha1md_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled digest word keeps its value.
  `SHA1MD_ASSERT(a_out_hold,
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
    "digest word changed while stalled")

  // The five digest words follow one another without a gap once taken.
  `SHA1MD_ASSERT(a_digest_burst, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid, "gap inside a digest")

  // After H4 is taken the next word, if any, opens a new digest.
  `SHA1MD_ASSERT(a_digest_end,
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid || !m_axis_tlast,
    "digest end followed by another last word")

  // A whole final word owes its pad word, so the input is not ready in the cycle after it is taken.
  `SHA1MD_ASSERT(a_pad_stall,
    s_axis_tvalid && s_axis_tready && s_axis_tlast && (s_axis_tuser > 3'd3) |=> !s_axis_tready,
    "input taken while the pad word was owed")

  // No result is offered while reset is held.
  `SHA1MD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "result offered in reset")

endmodule

bind sha1_message_digest sha1md_checker u_checker (.*);

/* sim/sha1_digest_checker.sv */
// Checker for the SHA-1 digest block: predicts the digest words and compares each output request.
module sha1_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        s_tlast_i,
  input  logic [2:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic        m_tlast_i,
  output int          errors_o,
  output int          outstanding_o,
  output int          digest_words_o,
  output int          messages_o,
  output int          extra_blocks_o
);

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  // Predicted hash state, tracked one input request at a time.
  logic [31:0]  chain_h [5];
  logic [31:0]  block_w [16];
  logic [3:0]   fill_pos;
  logic [63:0]  msg_bits;
  digest_beat_t digest_words_q [$];
  int           err_count;
  int           word_count;
  int           msg_count;
  int           extra_count;

  task automatic restart_message();
    for (int i = 0; i < 5; i++) begin
      chain_h[i] = sha1md_pkg::IV[i];
    end
    fill_pos = '0;
    msg_bits = '0;
  endtask

  // Runs the 80 rounds over the current block and folds them into the chaining words.
  task automatic sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wt, t;
    w = block_w;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        wt = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
        wt = {wt[30:0], wt[31]};
        w[r % 16] = wt;
      end
      case (r / 20)
        0: begin
          f = (b & c) | (~b & d);
          k = sha1md_pkg::K0;
        end
        1: begin
          f = b ^ c ^ d;
          k = sha1md_pkg::K1;
        end
        2: begin
          f = (b & c) | (b & d) | (c & d);
          k = sha1md_pkg::K2;
        end
        default: begin
          f = b ^ c ^ d;
          k = sha1md_pkg::K3;
        end
      endcase
      t = {a[26:0], a[31:27]} + f + e + wt + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endtask

  task automatic store_word(input logic [31:0] w);
    block_w[fill_pos] = w;
    fill_pos = fill_pos + 4'd1;
    if (fill_pos == 4'd0) begin
      sha1_compress();
    end
  endtask

  // Applies one accepted input request; a final word pads, closes the message and
  // queues the five digest words.
  task automatic absorb_request();
    int          nb;
    int          next;
    logic [31:0] keep;
    logic [31:0] tail;
    digest_beat_t beat;
    if (!s_tlast_i) begin
      store_word(s_tdata_i);
      msg_bits += 64'd32;
    end else begin
      nb = (s_tuser_i > 3'd4) ? 4 : int'(s_tuser_i);
      if (nb == 4) begin
        store_word(s_tdata_i);
        msg_bits += 64'd32;
        tail = sha1md_pkg::PAD_WORD;
      end else begin
        keep = (nb == 0) ? 32'h0 : ~(32'hFFFF_FFFF >> (8 * nb));
        tail = (s_tdata_i & keep) | (32'h80 << (24 - 8 * nb));
        msg_bits += 64'(8 * nb);
      end
      block_w[fill_pos] = tail;
      next = int'(fill_pos) + 1;
      // The pad byte left no room for the length, so one more block is needed.
      if (next > 14) begin
        for (int i = next; i < 16; i++) begin
          block_w[i] = '0;
        end
        sha1_compress();
        next = 0;
        extra_count++;
      end
      for (int i = next; i < 14; i++) begin
        block_w[i] = '0;
      end
      block_w[14] = msg_bits[63:32];
      block_w[15] = msg_bits[31:0];
      sha1_compress();
      for (int i = 0; i < 5; i++) begin
        beat.word = chain_h[i];
        beat.last = (i == 4);
        digest_words_q.push_back(beat);
      end
      msg_count++;
      restart_message();
    end
  endtask

  task automatic check_digest_word();
    digest_beat_t want;
    if (digest_words_q.size() == 0) begin
      $error("digest_word: unexpected output %08h with no digest pending", m_tdata_i);
      err_count++;
    end else begin
      want = digest_words_q.pop_front();
      word_count++;
      if (m_tdata_i !== want.word) begin
        $error("digest_word: expected %08h, got %08h", want.word, m_tdata_i);
        err_count++;
      end
      if (m_tlast_i !== want.last) begin
        $error("digest_last: expected %0b, got %0b", want.last, m_tlast_i);
        err_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
      for (int i = 0; i < 16; i++) begin
        block_w[i] = '0;
      end
      digest_words_q.delete();
      err_count = 0;
      word_count = 0;
      msg_count = 0;
      extra_count = 0;
    end else begin
      // Outputs first: a digest can never belong to a word accepted at the same edge.
      if (m_tvalid_i && m_tready_i) begin
        check_digest_word();
      end
      if (s_tvalid_i && s_tready_i) begin
        absorb_request();
      end
    end
    errors_o       <= err_count;
    outstanding_o  <= digest_words_q.size();
    digest_words_o <= word_count;
    messages_o     <= msg_count;
    extra_blocks_o <= extra_count;
  end

endmodule

/* sim/tb_top.sv */
// Top of the SHA-1 digest testbench: clock, reset, message stimulus, output stalls and verdict.
module tb_top;

  // Run length guard, far above the slowest legal run of about 410 words.
  localparam int CYCLE_LIMIT  = 600000;
  // Length of the one long receiver hold-off that backs the block up.
  localparam int LONG_HOLD    = 900;
  // Number of random message words to send after the directed part.
  localparam int RANDOM_WORDS = 390;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] message_word
  logic        s_axis_tlast;   // final_word
  logic [2:0]  s_axis_tuser;   // [2:0] valid_bytes
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] digest_word
  logic        m_axis_tlast;   // digest_last

  int errors;
  int outstanding;
  int digest_words;
  int messages;
  int extra_blocks;
  int cycle_count;
  int words_sent;

  // Set by the stimulus, taken once by the receiver process.
  bit hold_req;
  bit hold_taken;
  // While set, neither side inserts idle cycles.
  bit calm;

  sha1_message_digest u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  sha1_digest_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tlast_i     (s_axis_tlast),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tlast_i     (m_axis_tlast),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .digest_words_o(digest_words),
    .messages_o    (messages),
    .extra_blocks_o(extra_blocks)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hang anywhere in the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Idle stretch for either side: mostly none or short, now and then long.
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 55) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end else if (pick < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Message content with the extreme words showing up often.
  function automatic logic [31:0] message_word();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      return 32'h0000_0000;
    end else if (pick == 1) begin
      return 32'hFFFF_FFFF;
    end
    return $urandom;
  endfunction

  // Offers one request and returns at the edge that accepts it. The valid stays high on
  // return so back-to-back requests need no extra cycle.
  task automatic send_word(input logic [31:0] w, input logic fin, input logic [2:0] nb);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tlast  <= fin;
    s_axis_tuser  <= nb;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    words_sent++;
  endtask

  // A message of body_words whole words and a final word carrying fin_bytes.
  task automatic send_message(input int body_words, input logic [2:0] fin_bytes);
    for (int i = 0; i < body_words; i++) begin
      // The byte count is ignored on non-final words, so it is random there.
      send_word(message_word(), 1'b0, 3'($urandom_range(0, 7)));
    end
    send_word(message_word(), 1'b1, fin_bytes);
  endtask

  // Receiver: random stalls, plus one long hold-off counted here in cycles.
  initial begin
    int stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = idle_gap();
      end
    end
  end

  initial begin
    int msg;
    int body;
    int pick;
    logic [2:0] nb;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    s_axis_tuser  <= '0;
    cycle_count   <= 0;
    words_sent = 0;
    hold_req = 1'b0;
    hold_taken = 1'b0;
    calm = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Empty message: a final word with no valid bytes.
    send_word(32'hDEAD_BEEF, 1'b1, 3'd0);
    // "abc" with garbage in the unused byte, which must be masked.
    send_word(32'h6162_63FF, 1'b1, 3'd3);
    // One full final word of all ones, so the pad starts the next word.
    send_word(32'hFFFF_FFFF, 1'b1, 3'd4);
    // Byte counts above four saturate to four.
    send_word(32'h0000_0000, 1'b1, 3'd5);
    send_word(32'h0123_4567, 1'b1, 3'd6);
    send_word(32'h89AB_CDEF, 1'b1, 3'd7);
    // Pad byte lands in word 14: no room for the length, an extra block follows.
    send_message(14, 3'd2);

    // Random part: whole messages, their lengths biased toward the padding corners.
    msg = 0;
    while (words_sent < 21 + RANDOM_WORDS) begin
      calm = ((msg % 10) == 4);
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        body = $urandom_range(0, 12);
      end else if (pick < 8) begin
        body = $urandom_range(13, 15);
      end else if (pick < 9) begin
        body = 16 * $urandom_range(1, 2) + $urandom_range(0, 15);
      end else begin
        body = $urandom_range(0, 2);
      end
      // A short message whose digest is held off, then a long one that backs up behind it.
      if (msg == 6) begin
        hold_req = 1'b1;
        body = 3;
      end else if (msg == 7) begin
        body = 30;
      end
      nb = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
      send_message(body, nb);
      msg++;
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    while (outstanding != 0) begin
      @(posedge clk_i);
    end
    repeat (200) @(posedge clk_i);

    $display("Sent %0d words in %0d messages; %0d digest words checked.",
             words_sent, messages, digest_words);
    $display("%0d messages needed an extra padding block; final byte counts 0 to 7 used.",
             extra_blocks);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
